// ===== rtl/stcq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted timer callout queue: request and status codes,
// field widths and default parameter values. Depends on nothing.
package stcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int TIME_W   = 32;
    localparam int ID_W     = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EXPIRE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CANCELLED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTHING_DUE = 3'd5;

    // Compare unit modes: stop on a due time later than the key, or on an equal id.
    localparam logic CMP_DUE_GT = 1'b0;
    localparam logic CMP_ID_EQ  = 1'b1;

endpackage

// ===== rtl/stcq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on stcq_pkg for field widths.
interface stcq_req_if #(
    parameter int HANDLE_BITS = stcq_pkg::HANDLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [stcq_pkg::REQ_W-1:0]       req_type;
    logic [stcq_pkg::TIME_W-1:0]      due_time;
    logic [HANDLE_BITS-1:0]           entry_handle;
    logic [stcq_pkg::ID_W-1:0]        cancel_id;
    logic [stcq_pkg::TIME_W-1:0]      now_time;

    modport source (
        output valid, req_type, due_time, entry_handle, cancel_id, now_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, due_time, entry_handle, cancel_id, now_time,
        output ready
    );
endinterface

interface stcq_res_if #(
    parameter int HANDLE_BITS = stcq_pkg::HANDLE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [stcq_pkg::STATUS_W-1:0]    status;
    logic [stcq_pkg::ID_W-1:0]        result_id;
    logic [HANDLE_BITS-1:0]           result_handle;
    logic                             last;

    modport source (
        output valid, status, result_id, result_handle, last,
        input  ready
    );
    modport sink (
        input  valid, status, result_id, result_handle, last,
        output ready
    );
endinterface

// ===== rtl/stcq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module stcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/stcq_cmp.sv =====
`timescale 1ns / 1ps
// Shared compare unit of the queue sequencer: tests one stored entry against
// the request key. Depends on stcq_pkg for widths and mode codes.
module stcq_cmp (
    input  logic                         mode,
    input  logic [stcq_pkg::TIME_W-1:0]  slot_due,
    input  logic [stcq_pkg::ID_W-1:0]    slot_id,
    input  logic [stcq_pkg::TIME_W-1:0]  key,
    output logic                         stop
);

    always_comb
    begin
        case (mode)
            stcq_pkg::CMP_DUE_GT: stop = (slot_due > key);
            stcq_pkg::CMP_ID_EQ:  stop = (slot_id == key);
            default:              stop = 1'b0;
        endcase
    end

endmodule

// ===== rtl/sorted_timer_callout_queue.sv =====
`timescale 1ns / 1ps
// Top level of the sorted timer callout queue: sequencer, entry RAM and compare unit.
// Depends on stcq_pkg, stcq_if, stcq_ram and stcq_cmp.
//
//   Channel  Direction  Carries
//   req      in         req_type, due_time, entry_handle, cancel_id, now_time
//   res      out        status, result_id, result_handle, last
//
// One request is handled at a time; req.ready is high only while the sequencer is idle.
// Each scanned entry takes a read step and a compare step on the single RAM read port,
// and each moved entry a read step and a write step, before req.ready returns.
// An expire emits one transaction per due entry, or one nothing-due result if none is due.
// Results pass through an output register, so res.ready stalls only the emit steps.
// Reset clears the entry count, the id counter, the sequencer and the output valid.
module sorted_timer_callout_queue #(
    parameter int QUEUE_DEPTH = stcq_pkg::QUEUE_DEPTH_DEF,
    parameter int HANDLE_BITS = stcq_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    stcq_req_if.sink    req,
    stcq_res_if.source  res
);

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORD_W = stcq_pkg::TIME_W + stcq_pkg::ID_W + HANDLE_BITS;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_INS_RD   = 4'd3;
    localparam logic [3:0] S_INS_WR   = 4'd4;
    localparam logic [3:0] S_INS_PUT  = 4'd5;
    localparam logic [3:0] S_DEL_RD   = 4'd6;
    localparam logic [3:0] S_DEL_WR   = 4'd7;
    localparam logic [3:0] S_EXP_RD   = 4'd8;
    localparam logic [3:0] S_EXP_OUT  = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [stcq_pkg::ID_W-1:0]       next_id_reg, next_id_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic [CNT_W-1:0]                off_reg, off_next;
    logic [stcq_pkg::REQ_W-1:0]      op_reg, op_next;
    logic [stcq_pkg::TIME_W-1:0]     key_reg, key_next;
    logic [HANDLE_BITS-1:0]          handle_reg, handle_next;
    logic [stcq_pkg::STATUS_W-1:0]   st_status_reg, st_status_next;
    logic [stcq_pkg::ID_W-1:0]       st_id_reg, st_id_next;

    logic                            out_valid_reg, out_valid_next;
    logic [stcq_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [stcq_pkg::ID_W-1:0]       out_id_reg, out_id_next;
    logic [HANDLE_BITS-1:0]          out_handle_reg, out_handle_next;
    logic                            out_last_reg, out_last_next;

    logic                            ram_wr_en;
    logic [IDX_W-1:0]                ram_wr_addr;
    logic [WORD_W-1:0]               ram_wr_data;
    logic                            ram_rd_en;
    logic [IDX_W-1:0]                ram_rd_addr;
    logic [WORD_W-1:0]               ram_rd_data;

    logic [stcq_pkg::TIME_W-1:0]     rd_due;
    logic [stcq_pkg::ID_W-1:0]       rd_id;
    logic [HANDLE_BITS-1:0]          rd_handle;

    logic                            cmp_mode;
    logic                            cmp_stop;
    logic                            slot_free;
    logic                            req_fire;
    logic [CNT_W:0]                  src_idx;
    logic [CNT_W-1:0]                idx_dec;

    assign rd_due    = ram_rd_data[WORD_W-1 -: stcq_pkg::TIME_W];
    assign rd_id     = ram_rd_data[HANDLE_BITS +: stcq_pkg::ID_W];
    assign rd_handle = ram_rd_data[HANDLE_BITS-1:0];

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_free = !out_valid_reg || res.ready;
    assign src_idx   = {1'b0, idx_reg} + {1'b0, off_reg};
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign cmp_mode  = (op_reg == stcq_pkg::REQ_CANCEL) ? stcq_pkg::CMP_ID_EQ
                                                        : stcq_pkg::CMP_DUE_GT;

    stcq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stcq_cmp u_cmp (
        .mode     (cmp_mode),
        .slot_due (rd_due),
        .slot_id  (rd_id),
        .key      (key_reg),
        .stop     (cmp_stop)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        off_next        = off_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        st_status_next  = st_status_reg;
        st_id_next      = st_id_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_handle_next = out_handle_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = idx_reg[IDX_W-1:0];
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.req_type;
                    handle_next = req.entry_handle;
                    idx_next    = '0;
                    case (req.req_type)
                        stcq_pkg::REQ_INSERT:
                        begin
                            key_next = req.due_time;
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                st_status_next = stcq_pkg::ST_FULL;
                                st_id_next     = '0;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        stcq_pkg::REQ_CANCEL:
                        begin
                            key_next   = req.cancel_id;
                            state_next = S_SCAN_RD;
                        end
                        stcq_pkg::REQ_EXPIRE:
                        begin
                            key_next   = req.now_time;
                            state_next = S_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD, S_SCAN_CMP:
            begin
                if ((state_reg == S_SCAN_RD && idx_reg == count_reg) ||
                    (state_reg == S_SCAN_CMP && cmp_stop))
                begin
                    case (op_reg)
                        stcq_pkg::REQ_INSERT:
                        begin
                            pos_next = idx_reg;
                            idx_next = count_reg;
                            state_next = (idx_reg == count_reg) ? S_INS_PUT : S_INS_RD;
                        end
                        stcq_pkg::REQ_CANCEL:
                        begin
                            st_id_next = key_reg;
                            if (state_reg == S_SCAN_CMP)
                            begin
                                off_next   = CNT_W'(1);
                                state_next = S_DEL_RD;
                            end
                            else
                            begin
                                st_status_next = stcq_pkg::ST_NOT_FOUND;
                                state_next     = S_EMIT;
                            end
                        end
                        default:
                        begin
                            if (idx_reg == '0)
                            begin
                                st_status_next = stcq_pkg::ST_NOTHING_DUE;
                                st_id_next     = '0;
                                state_next     = S_EMIT;
                            end
                            else
                            begin
                                off_next   = idx_reg;
                                idx_next   = '0;
                                state_next = S_EXP_RD;
                            end
                        end
                    endcase
                end
                else if (state_reg == S_SCAN_RD)
                begin
                    ram_rd_en  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_INS_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_dec[IDX_W-1:0];
                state_next  = S_INS_WR;
            end
            S_INS_WR:
            begin
                ram_wr_en  = 1'b1;
                idx_next   = idx_dec;
                state_next = (idx_dec == pos_reg) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                ram_wr_en      = 1'b1;
                ram_wr_addr    = pos_reg[IDX_W-1:0];
                ram_wr_data    = {key_reg, next_id_reg, handle_reg};
                count_next     = count_reg + CNT_W'(1);
                next_id_next   = next_id_reg + stcq_pkg::ID_W'(1);
                st_status_next = stcq_pkg::ST_INSERTED;
                st_id_next     = next_id_reg;
                state_next     = S_EMIT;
            end
            S_DEL_RD:
            begin
                if (src_idx >= {1'b0, count_reg})
                begin
                    count_next = count_reg - off_reg;
                    if (op_reg == stcq_pkg::REQ_CANCEL)
                    begin
                        st_status_next = stcq_pkg::ST_CANCELLED;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = src_idx[IDX_W-1:0];
                    state_next  = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                ram_wr_en  = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DEL_RD;
            end
            S_EXP_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_EXP_OUT;
            end
            S_EXP_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stcq_pkg::ST_EXPIRED;
                    out_id_next     = rd_id;
                    out_handle_next = rd_handle;
                    out_last_next   = (idx_reg + CNT_W'(1) == off_reg);
                    if (idx_reg + CNT_W'(1) == off_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_DEL_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_EXP_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_status_reg;
                    out_id_next     = st_id_reg;
                    out_handle_next = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        off_reg        <= off_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        st_status_reg  <= st_status_next;
        st_id_reg      <= st_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_handle_reg <= out_handle_next;
        out_last_reg   <= out_last_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.result_id     = out_id_reg;
    assign res.result_handle = out_handle_reg;
    assign res.last          = out_last_reg;

endmodule
